FILE: rtl/tip_pkg.sv
// ----------------------------------------------------------------------------
// tip_pkg
// Shared types, constants and the lookup function of the interactivity and
// priority block.
// ----------------------------------------------------------------------------
`default_nettype none

package tip_pkg;

   localparam int RUN_W      = 16;
   localparam int SLP_W      = 32;
   localparam int NICE_W     = 6;
   localparam int TCK_W      = 32;
   localparam int CPU_W      = 48;
   localparam int HIST_W     = 13;
   localparam int DIV_W      = 38;
   localparam int SCORE_W    = 8;
   localparam int PRIO_W     = 7;
   localparam int MS_W       = 10;
   localparam int HALF_W     = 6;
   localparam int CSR_IDX_W  = 3;

   localparam int BQ_BITS    = 8;
   localparam int SQ_BITS    = 6;
   localparam int NSTEP      = BQ_BITS;

   localparam int QDEPTH     = 4;
   localparam int QAW        = 2;
   localparam int QCW        = 3;

   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 80;

   localparam logic [32:0] WINDOW_MS     = 33'd5000;
   localparam logic [32:0] WINDOW_HARD   = 33'd10000;
   localparam logic [32:0] WINDOW_HALF   = 33'd6000;
   localparam logic [15:0] RECIP5        = 16'd52429;
   localparam int          RECIP5_SHIFT  = 18;
   localparam logic [6:0]  SCALE         = 7'd50;
   localparam logic signed [SCORE_W-1:0] THRESHOLD     = 8'sd30;
   localparam logic signed [SCORE_W-1:0] SCORE_NOSLEEP = 8'sd100;
   localparam logic signed [SCORE_W-1:0] SCORE_MAX     = 8'sd127;
   localparam int          PRIO_SHIFT    = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MS_PER_TICK = 3'd0,
      CSR_INTER_BASE  = 3'd1,
      CSR_BATCH_LOW   = 3'd2,
      CSR_BATCH_HIGH  = 3'd3,
      CSR_HALF_RANGE  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [MS_W-1:0]   ms_per_tick;
      logic [PRIO_W-1:0] inter_base;
      logic [PRIO_W-1:0] batch_low;
      logic [PRIO_W-1:0] batch_high;
      logic [HALF_W-1:0] half_range;
   } cfg_type;

   typedef struct packed {
      logic [RUN_W:0]              run;
      logic [SLP_W-1:0]            slp;
      logic [TCK_W-1:0]            ticks;
      logic signed [NICE_W-1:0]    nice;
      logic [CPU_W-1:0]            cpu;
      logic [DIV_W-1:0]            div;
   } front_type;

   typedef struct packed {
      logic [HIST_W-1:0]           run;
      logic [HIST_W-1:0]           slp;
      logic [TCK_W-1:0]            ticks;
      logic signed [NICE_W-1:0]    nice;
      logic [CPU_W-1:0]            cpu;
      logic [DIV_W-1:0]            div;
   } item_type;

   typedef struct packed {
      logic [HIST_W-1:0]           run;
      logic [HIST_W-1:0]           slp;
      logic [TCK_W-1:0]            ticks;
      logic signed [NICE_W-1:0]    nice;
      logic [HIST_W-1:0]           srem;
      logic [HIST_W-1:0]           sden;
      logic [SQ_BITS:0]            sq;
      logic [CPU_W-1:0]            brem;
      logic [DIV_W-1:0]            bdiv;
      logic [BQ_BITS:0]            bq;
   } stage_type;

   // 50 / q for a ratio quotient saturated at 64
   function automatic logic [6:0] pen_lut(input logic [SQ_BITS:0] q);
      logic [6:0] r;
      case (q) inside
         7'd1:             r = 7'd50;
         7'd2:             r = 7'd25;
         7'd3:             r = 7'd16;
         7'd4:             r = 7'd12;
         7'd5:             r = 7'd10;
         7'd6:             r = 7'd8;
         7'd7:             r = 7'd7;
         7'd8:             r = 7'd6;
         [7'd9:7'd10]:     r = 7'd5;
         [7'd11:7'd12]:    r = 7'd4;
         [7'd13:7'd16]:    r = 7'd3;
         [7'd17:7'd25]:    r = 7'd2;
         [7'd26:7'd50]:    r = 7'd1;
         default:          r = 7'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/tip_front.sv
// ----------------------------------------------------------------------------
// tip_front
// Accepts request words, applies the tick charge or wake, forms the batch
// divisor and clamps the run and sleep histories before queueing.
// ----------------------------------------------------------------------------
`default_nettype none

module tip_front
   import tip_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cfg_type               cfg,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   input  wire logic                  q_full,
   output logic                       q_push,
   output item_type                   q_item
);

   logic      s1_valid_ff, s1_valid_in;
   front_type s1_ff, s1_in;
   logic      accept;

   logic [RUN_W-1:0]  in_run;
   logic [SLP_W-1:0]  in_slp;
   logic [NICE_W-1:0] in_nice;
   logic [TCK_W-1:0]  in_ticks;
   logic [CPU_W-1:0]  in_cpu;
   logic [TCK_W-1:0]  ticks_new;
   logic [TCK_W-1:0]  t_eff;
   logic [HALF_W-1:0] h_eff;

   logic [32:0]       sum;
   logic [28:0]       prod_r, prod_s;
   logic [10:0]       fifth_r, fifth_s;

   assign in_run   = req_tdata[15:0];
   assign in_slp   = req_tdata[47:16];
   assign in_nice  = req_tdata[53:48];
   assign in_ticks = req_tdata[85:54];
   assign in_cpu   = req_tdata[133:86];

   assign req_tready = !s1_valid_ff || !q_full;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = s1_valid_ff && !q_full;

   always_comb begin
      if (!req_tuser && (in_ticks != '1)) begin
         ticks_new = in_ticks + TCK_W'(1);
      end else begin
         ticks_new = in_ticks;
      end
      t_eff = (ticks_new == '0) ? TCK_W'(1) : ticks_new;
      h_eff = (cfg.half_range == '0) ? HALF_W'(1) : cfg.half_range;

      s1_in.run   = req_tuser ? {1'b0, in_run}
                              : {1'b0, in_run} + (RUN_W + 1)'(cfg.ms_per_tick);
      s1_in.slp   = in_slp;
      s1_in.ticks = ticks_new;
      s1_in.nice  = in_nice;
      s1_in.cpu   = in_cpu;
      s1_in.div   = DIV_W'(t_eff) * DIV_W'(h_eff);

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (q_push) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // window clamp
   always_comb begin
      sum     = 33'(s1_ff.run) + 33'(s1_ff.slp);
      prod_r  = 29'(s1_ff.run[HIST_W-1:0]) * 29'(RECIP5);
      prod_s  = 29'(s1_ff.slp[HIST_W-1:0]) * 29'(RECIP5);
      fifth_r = prod_r[28:RECIP5_SHIFT];
      fifth_s = prod_s[28:RECIP5_SHIFT];

      q_item.ticks = s1_ff.ticks;
      q_item.nice  = s1_ff.nice;
      q_item.cpu   = s1_ff.cpu;
      q_item.div   = s1_ff.div;

      if (sum < WINDOW_MS) begin
         q_item.run = s1_ff.run[HIST_W-1:0];
         q_item.slp = s1_ff.slp[HIST_W-1:0];
      end else if (sum > WINDOW_HARD) begin
         if (33'(s1_ff.run) > 33'(s1_ff.slp)) begin
            q_item.run = HIST_W'(WINDOW_MS);
            q_item.slp = HIST_W'(1);
         end else begin
            q_item.run = HIST_W'(1);
            q_item.slp = HIST_W'(WINDOW_MS);
         end
      end else if (sum > WINDOW_HALF) begin
         q_item.run = s1_ff.run[HIST_W:1];
         q_item.slp = s1_ff.slp[HIST_W:1];
      end else begin
         q_item.run = {fifth_r, 2'b00};
         q_item.slp = {fifth_s, 2'b00};
      end
   end

endmodule

`default_nettype wire

FILE: rtl/tip_queue.sv
// ----------------------------------------------------------------------------
// tip_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module tip_queue
   import tip_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type item_in,
   output logic          full,
   input  wire logic     pop,
   output item_type      item_out,
   output logic          empty
);

   item_type         mem_ff [QDEPTH];
   logic [QAW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QCW-1:0]   cnt_ff, cnt_in;

   assign full     = (cnt_ff == QCW'(QDEPTH));
   assign empty    = (cnt_ff == '0);
   assign item_out = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + QAW'(1) : wr_ff;
      rd_in  = pop  ? rd_ff + QAW'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + QCW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= item_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/tip_back.sv
// ----------------------------------------------------------------------------
// tip_back
// Pipelined ratio and batch dividers, score and priority selection, and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tip_back
   import tip_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cfg_type                cfg,
   input  wire item_type               q_item,
   input  wire logic                   q_empty,
   output logic                        q_pop,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   output logic                        rsp_tuser
);

   stage_type stg_ff [NSTEP+1];
   stage_type stg_in [NSTEP+1];
   logic      vld_ff [NSTEP+1];
   logic      vld_in [NSTEP+1];

   logic                    out_vld_ff, out_vld_in;
   logic [RSP_DATA_W-1:0]   out_data_ff, out_data_in;
   logic                    out_user_ff, out_user_in;
   logic                    adv;

   logic [HIST_W-1:0]       num0, den0;
   logic [CPU_W-1:0]        dsh;
   logic [HIST_W+SQ_BITS-1:0] ssh;

   stage_type               f;
   logic                    slp_gt;
   logic [6:0]              pen;
   logic signed [9:0]       pen_s;
   logic signed [SCORE_W-1:0] score;
   logic                    inter;
   logic signed [9:0]       diff;
   logic [7:0]              iprio_w;
   logic [PRIO_W-1:0]       prio;
   logic [BQ_BITS+1:0]      qc;
   logic signed [11:0]      pv;

   assign adv   = !out_vld_ff || rsp_tready;
   assign q_pop = adv && !q_empty;

   always_comb begin
      num0 = (q_item.slp > q_item.run) ? q_item.slp : q_item.run;
      den0 = (q_item.slp > q_item.run) ? q_item.run : q_item.slp;

      stg_in[0].run   = q_item.run;
      stg_in[0].slp   = q_item.slp;
      stg_in[0].ticks = q_item.ticks;
      stg_in[0].nice  = q_item.nice;
      stg_in[0].srem  = num0;
      stg_in[0].sden  = den0;
      stg_in[0].sq    = ((HIST_W+SQ_BITS)'(num0) >= ((HIST_W+SQ_BITS)'(den0) << SQ_BITS))
                        ? (SQ_BITS+1)'(1 << SQ_BITS) : '0;
      stg_in[0].brem  = q_item.cpu;
      stg_in[0].bdiv  = q_item.div;
      stg_in[0].bq    = (q_item.cpu >= {q_item.div, {BQ_BITS{1'b0}}}
                         ) ? (BQ_BITS+1)'(1 << BQ_BITS) : '0;
      vld_in[0]       = q_pop;

      for (int k = 0; k < NSTEP; k++) begin
         stg_in[k+1] = stg_ff[k];
         vld_in[k+1] = vld_ff[k];
         dsh = CPU_W'(stg_ff[k].bdiv) << (BQ_BITS - 1 - k);
         if (!stg_ff[k].bq[BQ_BITS] && (stg_ff[k].brem >= dsh)) begin
            stg_in[k+1].brem = stg_ff[k].brem - dsh;
            stg_in[k+1].bq[BQ_BITS-1-k] = 1'b1;
         end
         if (k < SQ_BITS) begin
            ssh = (HIST_W+SQ_BITS)'(stg_ff[k].sden) << (SQ_BITS - 1 - k);
            if (!stg_ff[k].sq[SQ_BITS] &&
                ((HIST_W+SQ_BITS)'(stg_ff[k].srem) >= ssh)) begin
               stg_in[k+1].srem = stg_ff[k].srem - HIST_W'(ssh);
               stg_in[k+1].sq[SQ_BITS-1-k] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= NSTEP; k++) begin
            stg_ff[k] <= stg_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NSTEP; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         for (int k = 0; k <= NSTEP; k++) begin
            vld_ff[k] <= vld_in[k];
         end
      end
   end

   // score and priority
   always_comb begin
      f      = stg_ff[NSTEP];
      slp_gt = f.slp > f.run;
      pen    = pen_lut(f.sq) + (slp_gt ? 7'd0 : SCALE);
      pen_s  = $signed({3'b000, pen}) + 10'(f.nice);

      if (f.slp == '0) begin
         score = SCORE_NOSLEEP;
      end else if (f.run == '0) begin
         score = '0;
      end else if (pen_s > 10'(SCORE_MAX)) begin
         score = SCORE_MAX;
      end else begin
         score = pen_s[SCORE_W-1:0];
      end

      inter   = score < THRESHOLD;
      diff    = 10'(THRESHOLD) - 10'(score);
      iprio_w = {1'b0, cfg.inter_base} + 8'(diff[9:PRIO_SHIFT]);

      qc = (BQ_BITS+2)'(f.bq) + ((f.brem != '0) ? (BQ_BITS+2)'(1) : '0);
      pv = $signed({2'b00, qc}) - 12'(f.nice);

      if (inter) begin
         prio = iprio_w[7] ? '1 : iprio_w[PRIO_W-1:0];
      end else if (pv < $signed({5'b0, cfg.batch_low})) begin
         prio = cfg.batch_low;
      end else if (pv > $signed({5'b0, cfg.batch_high})) begin
         prio = cfg.batch_high;
      end else begin
         prio = pv[PRIO_W-1:0];
      end

      out_vld_in  = adv ? vld_ff[NSTEP] : out_vld_ff;
      out_data_in = out_data_ff;
      out_user_in = out_user_ff;
      if (adv) begin
         out_data_in = RSP_DATA_W'({prio, score, f.ticks, f.slp, f.run});
         out_user_in = inter;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      out_user_ff <= out_user_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

`default_nettype wire

FILE: rtl/thread_interactivity_priority.sv
// ----------------------------------------------------------------------------
// thread_interactivity_priority
// Thread run/sleep history clamp, interactivity score and priority.
// ----------------------------------------------------------------------------
// One request word per thread record enters on req_*, one result word per
// record leaves on rsp_*, in order. req_tuser is the command: tick charge
// (low) or wake (high). rsp_tuser flags an interactive thread.
// The csr_* port writes the five settings; write them only while idle.
// From accepted request to result valid a word passes one front register,
// one queue slot, nine divider stages and the result register.
// One word per cycle passes unless the receiver stalls; the batch divider
// is pipelined, one quotient bit per stage, eight stages, capped at 256.
// When the receiver stalls the back pipeline holds, the four-entry queue
// fills and req_tready then drops; the front keeps taking words until the
// queue and the front register are full. Reset empties the pipeline and
// queue and loads the setting defaults: 10 ms per tick, interactive base
// 32, batch range 1..31, half range 15. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module thread_interactivity_priority
   import tip_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // runtime_ms[15:0] sleep_ms[47:16] nice[53:48] thread_ticks[85:54]
   // cpu_ticks[133:86], zero fill above
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // command[0]
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // runtime_out[12:0] sleep_out[25:13] ticks_out[57:26] score[65:58]
   // new_priority[72:66], zero fill above
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // is_interactive[0]
   output logic                       rsp_tuser,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [MS_W-1:0]       csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     q_push, q_pop, q_full, q_empty;
   item_type q_in, q_out;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MS_PER_TICK: cfg_in.ms_per_tick = csr_wdata;
            CSR_INTER_BASE:  cfg_in.inter_base  = csr_wdata[PRIO_W-1:0];
            CSR_BATCH_LOW:   cfg_in.batch_low   = csr_wdata[PRIO_W-1:0];
            CSR_BATCH_HIGH:  cfg_in.batch_high  = csr_wdata[PRIO_W-1:0];
            CSR_HALF_RANGE:  cfg_in.half_range  = csr_wdata[HALF_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ms_per_tick <= MS_W'(10);
         cfg_ff.inter_base  <= PRIO_W'(32);
         cfg_ff.batch_low   <= PRIO_W'(1);
         cfg_ff.batch_high  <= PRIO_W'(31);
         cfg_ff.half_range  <= HALF_W'(15);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tip_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (q_in)
   );

   tip_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .item_in  (q_in),
      .full     (q_full),
      .pop      (q_pop),
      .item_out (q_out),
      .empty    (q_empty)
   );

   tip_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_item     (q_out),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

FILE: rtl/tip_checker.sv
// ----------------------------------------------------------------------------
// tip_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tip_checker
   import tip_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tuser
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   a_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == ($signed(rsp_tdata[65:58]) < THRESHOLD))
      else $error("interactive flag disagrees with score");

   a_window: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[12:0] <= 13'd5000) && (rsp_tdata[25:13] <= 13'd5000))
      else $error("history outside window");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind thread_interactivity_priority tip_checker u_tip_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
